// File: hdl/lspd_pkg.sv
package lspd_pkg;

  // Field widths of the channels and the configuration port.
  localparam int SENSOR_W   = 5;
  localparam int DRIVE_W    = 8;
  localparam int CTRL_W     = 24;
  localparam int POS_W      = 7;
  localparam int GAIN_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Internal widths: error is -96..95, error change is -191..191.
  localparam int ERR_W   = 8;
  localparam int DERIV_W = 9;
  localparam int ACC_W   = 34;
  localparam int DRV_W   = 25;

  // Drive ceiling and floor.
  localparam int PWM_BITS  = 8;
  localparam int MIN_SPEED = 0;

  // Values after reset.
  localparam logic [GAIN_W-1:0]       GAIN_P_RST = 8'd80;
  localparam logic [GAIN_W-1:0]       GAIN_I_RST = 8'd0;
  localparam logic [GAIN_W-1:0]       GAIN_D_RST = 8'd1;
  localparam logic signed [POS_W-1:0] TARGET_RST = 7'sd0;
  localparam logic [DRIVE_W-1:0]      BASE_RST   = 8'd200;
  localparam logic [DRIVE_W-1:0]      MAX_RST    = 8'd200;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_TARGET     = 3'd3,
    REG_BASE_LEFT  = 3'd4,
    REG_BASE_RIGHT = 3'd5,
    REG_MAX_LEFT   = 3'd6,
    REG_MAX_RIGHT  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [GAIN_W-1:0]       gain_p;
    logic [GAIN_W-1:0]       gain_i;
    logic [GAIN_W-1:0]       gain_d;
    logic signed [POS_W-1:0] target;
    logic [DRIVE_W-1:0]      base_left;
    logic [DRIVE_W-1:0]      base_right;
    logic [DRIVE_W-1:0]      max_left;
    logic [DRIVE_W-1:0]      max_right;
  } cfg_t;

  // What the front end hands to the control law for one request.
  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [CTRL_W-1:0]  sum;
    logic signed [DERIV_W-1:0] deriv;
    logic signed [POS_W-1:0]   pos;
  } stage_t;

  typedef struct packed {
    logic                    hit;
    logic signed [POS_W-1:0] pos;
  } decode_t;

  // Maps a sensor pattern to a line position; unknown patterns miss.
  function automatic decode_t decode_sensor(input logic [SENSOR_W-1:0] bits);
    decode_t r;
    r.hit = 1'b1;
    case (bits)
      5'b11011: r.pos = 7'sd0;
      5'b11001: r.pos = 7'sd1;
      5'b11101: r.pos = 7'sd2;
      5'b11100: r.pos = 7'sd7;
      5'b11110: r.pos = 7'sd13;
      5'b11000: r.pos = 7'sd32;
      5'b11111: r.pos = 7'sd0;
      5'b10011: r.pos = -7'sd1;
      5'b10111: r.pos = -7'sd2;
      5'b00111: r.pos = -7'sd7;
      5'b01111: r.pos = -7'sd13;
      5'b00011: r.pos = -7'sd32;
      default: begin
        r.hit = 1'b0;
        r.pos = 7'sd0;
      end
    endcase
    return r;
  endfunction

  // Saturates a wide signed value to the 24-bit signed range.
  function automatic logic signed [CTRL_W-1:0] sat_ctrl(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(  (64'sd1 <<< (CTRL_W - 1)) - 64'sd1);
    lo = ACC_W'(-(64'sd1 <<< (CTRL_W - 1)));
    if (v > hi) begin
      return hi[CTRL_W-1:0];
    end else if (v < lo) begin
      return lo[CTRL_W-1:0];
    end else begin
      return v[CTRL_W-1:0];
    end
  endfunction

endpackage

// File: hdl/lspd_if.sv
interface lspd_in_if;
  logic                           valid;
  logic                           ready;
  logic [lspd_pkg::SENSOR_W-1:0]  sensor_bits;

  modport source (output valid, output sensor_bits, input ready);
  modport sink   (input valid, input sensor_bits, output ready);
endinterface

interface lspd_out_if;
  logic                               valid;
  logic                               ready;
  logic [lspd_pkg::DRIVE_W-1:0]       left_drive;
  logic [lspd_pkg::DRIVE_W-1:0]       right_drive;
  logic signed [lspd_pkg::CTRL_W-1:0] control_value;
  logic signed [lspd_pkg::POS_W-1:0]  line_position;

  modport source (output valid, output left_drive, output right_drive,
                  output control_value, output line_position, input ready);
  modport sink   (input valid, input left_drive, input right_drive,
                  input control_value, input line_position, output ready);
endinterface

// File: hdl/lspd_law.sv
module lspd_law (
  input  lspd_pkg::cfg_t                     cfg_i,
  input  lspd_pkg::stage_t                   stage_i,
  output logic [lspd_pkg::DRIVE_W-1:0]       left_drive_o,
  output logic [lspd_pkg::DRIVE_W-1:0]       right_drive_o,
  output logic signed [lspd_pkg::CTRL_W-1:0] control_o
);
  import lspd_pkg::*;

  localparam logic signed [DRV_W-1:0] MinDrive = DRV_W'(MIN_SPEED);
  localparam logic signed [DRV_W-1:0] TopDrive = DRV_W'((1 << PWM_BITS) - 1);

  logic signed [GAIN_W+ERR_W:0]    p_prod;
  logic signed [GAIN_W+CTRL_W:0]   i_prod;
  logic signed [GAIN_W+DERIV_W:0]  d_prod;
  logic signed [ACC_W-1:0]         acc;
  logic signed [CTRL_W-1:0]        ctrl;
  logic signed [DRV_W-1:0]         left;
  logic signed [DRV_W-1:0]         right;
  logic signed [DRV_W-1:0]         left_c;
  logic signed [DRV_W-1:0]         right_c;
  logic signed [DRV_W-1:0]         left_l;
  logic signed [DRV_W-1:0]         right_l;

  always_comb begin
    p_prod = $signed({1'b0, cfg_i.gain_p}) * stage_i.err;
    i_prod = $signed({1'b0, cfg_i.gain_i}) * stage_i.sum;
    d_prod = $signed({1'b0, cfg_i.gain_d}) * stage_i.deriv;
    acc    = ACC_W'(p_prod) + ACC_W'(i_prod) + ACC_W'(d_prod);
    ctrl   = sat_ctrl(acc);

    left  = $signed({{(DRV_W-DRIVE_W){1'b0}}, cfg_i.base_left}) + DRV_W'(ctrl);
    right = $signed({{(DRV_W-DRIVE_W){1'b0}}, cfg_i.base_right}) - DRV_W'(ctrl);

    // Left: the upper clamp takes priority over the floor.
    if (left > $signed({{(DRV_W-DRIVE_W){1'b0}}, cfg_i.max_left})) begin
      left_c = $signed({{(DRV_W-DRIVE_W){1'b0}}, cfg_i.max_left});
    end else if (left < MinDrive) begin
      left_c = MinDrive;
    end else begin
      left_c = left;
    end

    // Right: the floor is applied after the upper clamp and wins.
    right_c = right;
    if (right_c > $signed({{(DRV_W-DRIVE_W){1'b0}}, cfg_i.max_right})) begin
      right_c = $signed({{(DRV_W-DRIVE_W){1'b0}}, cfg_i.max_right});
    end
    if (right_c < MinDrive) begin
      right_c = MinDrive;
    end

    // Final PWM range limit.
    left_l = left_c;
    if (left_l > TopDrive) begin
      left_l = TopDrive;
    end
    if (left_l < 0) begin
      left_l = '0;
    end
    right_l = right_c;
    if (right_l > TopDrive) begin
      right_l = TopDrive;
    end
    if (right_l < 0) begin
      right_l = '0;
    end

    left_drive_o  = left_l[DRIVE_W-1:0];
    right_drive_o = right_l[DRIVE_W-1:0];
    control_o     = ctrl;
  end

endmodule

// File: hdl/line_sensor_pid_differential_drive_top.sv
// Path: an accepted request goes into the stage register, then into the
// output register, which presents its result on the output channel.
// Throughput: one request per cycle unless the output stalls; the two pipeline
// registers decouple the channels so a new sample is taken while a finished result waits.
// Reset (rst_ni low, asynchronous) empties the pipeline, clears the held
// position, the error sum and the last error, and loads the default configuration.
module line_sensor_pid_differential_drive_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lspd_in_if.sink                         sensor_i,
  lspd_out_if.source                      result_o,
  input  logic                            cfg_we_i,
  input  logic [lspd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lspd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lspd_pkg::*;

  // Configuration registers.
  cfg_t cfg_q;

  // Controller state that carries from one sample to the next.
  logic signed [POS_W-1:0]  held_pos_q;
  logic signed [CTRL_W-1:0] err_sum_q;
  logic signed [ERR_W-1:0]  prev_err_q;

  // Front end result: the stage register between decode and control law.
  logic   s1_vq;
  stage_t s1_q;
  stage_t s1_d;

  // Output register.
  logic                     out_vq;
  logic [DRIVE_W-1:0]       left_q;
  logic [DRIVE_W-1:0]       right_q;
  logic signed [CTRL_W-1:0] ctrl_q;
  logic signed [POS_W-1:0]  pos_q;

  logic                     in_fire;
  logic                     s1_move;
  decode_t                  dec;
  logic signed [POS_W-1:0]  pos_d;
  logic signed [ERR_W-1:0]  err_d;
  logic signed [CTRL_W:0]   sum_wide;
  logic signed [CTRL_W-1:0] sum_d;
  logic [DRIVE_W-1:0]       left_d;
  logic [DRIVE_W-1:0]       right_d;
  logic signed [CTRL_W-1:0] ctrl_d;

  // The stage register advances when the output register is empty or its
  // result is being taken; the input side follows the stage register.
  assign s1_move        = s1_vq && (!out_vq || result_o.ready);
  assign sensor_i.ready = !s1_vq || s1_move;
  assign in_fire        = sensor_i.valid && sensor_i.ready;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p     <= GAIN_P_RST;
      cfg_q.gain_i     <= GAIN_I_RST;
      cfg_q.gain_d     <= GAIN_D_RST;
      cfg_q.target     <= TARGET_RST;
      cfg_q.base_left  <= BASE_RST;
      cfg_q.base_right <= BASE_RST;
      cfg_q.max_left   <= MAX_RST;
      cfg_q.max_right  <= MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_GAIN_P:     cfg_q.gain_p     <= cfg_data_i;
        REG_GAIN_I:     cfg_q.gain_i     <= cfg_data_i;
        REG_GAIN_D:     cfg_q.gain_d     <= cfg_data_i;
        REG_TARGET:     cfg_q.target     <= $signed(cfg_data_i[POS_W-1:0]);
        REG_BASE_LEFT:  cfg_q.base_left  <= cfg_data_i;
        REG_BASE_RIGHT: cfg_q.base_right <= cfg_data_i;
        REG_MAX_LEFT:   cfg_q.max_left   <= cfg_data_i;
        REG_MAX_RIGHT:  cfg_q.max_right  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front end: decode the sample, form the error, update the saturating sum
  // and the error change. An unknown pattern keeps the held position.
  always_comb begin
    dec      = decode_sensor(sensor_i.sensor_bits);
    pos_d    = dec.hit ? dec.pos : held_pos_q;
    err_d    = ERR_W'(cfg_q.target) - ERR_W'(pos_d);
    sum_wide = (CTRL_W+1)'(err_sum_q) + (CTRL_W+1)'(err_d);
    sum_d    = sat_ctrl(ACC_W'(sum_wide));

    s1_d.err   = err_d;
    s1_d.sum   = sum_d;
    s1_d.deriv = DERIV_W'(err_d) - DERIV_W'(prev_err_q);
    s1_d.pos   = pos_d;
  end

  // State moves with each accepted request, so the stage register always
  // carries the newest one and the next sample sees its effect at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_pos_q <= '0;
      err_sum_q  <= '0;
      prev_err_q <= '0;
      s1_vq      <= 1'b0;
    end else begin
      if (in_fire) begin
        held_pos_q <= s1_d.pos;
        err_sum_q  <= s1_d.sum;
        prev_err_q <= s1_d.err;
      end
      if (in_fire) begin
        s1_vq <= 1'b1;
      end else if (s1_move) begin
        s1_vq <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
  end

  // Control law: the three gain products, saturation and drive clamping.
  lspd_law u_law (
    .cfg_i         (cfg_q),
    .stage_i       (s1_q),
    .left_drive_o  (left_d),
    .right_drive_o (right_d),
    .control_o     (ctrl_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (s1_move) begin
      out_vq <= 1'b1;
    end else if (result_o.ready) begin
      out_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      left_q  <= left_d;
      right_q <= right_d;
      ctrl_q  <= ctrl_d;
      pos_q   <= s1_q.pos;
    end
  end

  assign result_o.valid         = out_vq;
  assign result_o.left_drive    = left_q;
  assign result_o.right_drive   = right_q;
  assign result_o.control_value = ctrl_q;
  assign result_o.line_position = pos_q;

  // A full pipeline with a stalled output must refuse new samples.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vq && out_vq && !result_o.ready |-> !sensor_i.ready)
    else $error("sample accepted while pipeline full and stalled");

  // The stage register always holds the request that last updated the state.
  a_stage_latest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vq |-> (prev_err_q == s1_q.err) && (held_pos_q == s1_q.pos)
              && (err_sum_q == s1_q.sum))
    else $error("stage register out of step with controller state");

  // An accepted sample lands in the stage register.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sensor_i.valid && sensor_i.ready |=> s1_vq)
    else $error("accepted sample was lost");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

// Testbench for the line-sensor PID differential drive controller.
// Sensor samples go in on the request channel and each one yields exactly one
// drive result. A model of the control law in this file predicts every
// result at the moment its request is accepted, and a checker compares the
// results against those predictions in order.
module tb_top;
  import lspd_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int REPORT_MAX  = 10;

  // The twelve sensor patterns that decode to a line position.
  localparam logic [SENSOR_W-1:0] LINE_PATTERNS [12] = '{
    5'b11011, 5'b11001, 5'b11101, 5'b11100, 5'b11110, 5'b11000,
    5'b11111, 5'b10011, 5'b10111, 5'b00111, 5'b01111, 5'b00011
  };

  // Configuration sets that the random phases pick from.
  typedef enum int {
    CFG_RANDOM,
    CFG_ALL_HIGH,
    CFG_ALL_LOW
  } cfg_pick_e;

  // One drive result, as predicted or as seen on the output channel.
  typedef struct packed {
    logic [DRIVE_W-1:0] left_drive;
    logic [DRIVE_W-1:0] right_drive;
    logic [CTRL_W-1:0]  control_value;
    logic [POS_W-1:0]   line_position;
  } drive_result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  lspd_in_if  sensor_if ();
  lspd_out_if result_if ();

  line_sensor_pid_differential_drive_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sensor_i   (sensor_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Results still owed by the block, oldest first.
  drive_result_t expected_drive_q [$];
  int unsigned   drive_mismatches;
  int unsigned   cycle_count;

  // When set, both sides insert random idle bursts.
  bit idle_en;
  int stall_left;

  // Controller state and register copy used for prediction. Values are kept
  // as plain integers so the arithmetic below never wraps.
  int     gain_p_q, gain_i_q, gain_d_q, setpoint_q;
  int     base_left_q, base_right_q, max_left_q, max_right_q;
  int     pos_held;
  longint err_acc;
  longint err_last;

  // 100 MHz clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Clamps a wide value into the signed 24-bit range.
  function automatic longint clamp24(input longint v);
    if (v > 64'sd8388607) begin
      return 64'sd8388607;
    end
    if (v < -64'sd8388608) begin
      return -64'sd8388608;
    end
    return v;
  endfunction

  // Mirrors one register write into the prediction state.
  function automatic void apply_reg(input cfg_reg_e r, input logic [CFG_DATA_W-1:0] d);
    case (r)
      REG_GAIN_P:     gain_p_q     = int'(d);
      REG_GAIN_I:     gain_i_q     = int'(d);
      REG_GAIN_D:     gain_d_q     = int'(d);
      REG_TARGET:     setpoint_q   = int'($signed(d[POS_W-1:0]));
      REG_BASE_LEFT:  base_left_q  = int'(d);
      REG_BASE_RIGHT: base_right_q = int'(d);
      REG_MAX_LEFT:   max_left_q   = int'(d);
      REG_MAX_RIGHT:  max_right_q  = int'(d);
      default: ;
    endcase
  endfunction

  // Advances the controller state by one sample and returns its drive result.
  function automatic drive_result_t predict_drive(input logic [SENSOR_W-1:0] bits);
    drive_result_t res;
    longint err;
    longint ctrl;
    longint left;
    longint right;
    longint ceiling;
    ceiling = (64'sd1 <<< PWM_BITS) - 1;
    // An unknown pattern leaves the held position as it was.
    case (bits)
      5'b11011: pos_held = 0;
      5'b11001: pos_held = 1;
      5'b11101: pos_held = 2;
      5'b11100: pos_held = 7;
      5'b11110: pos_held = 13;
      5'b11000: pos_held = 32;
      5'b11111: pos_held = 0;
      5'b10011: pos_held = -1;
      5'b10111: pos_held = -2;
      5'b00111: pos_held = -7;
      5'b01111: pos_held = -13;
      5'b00011: pos_held = -32;
      default: ;
    endcase
    err      = longint'(setpoint_q) - longint'(pos_held);
    err_acc  = clamp24(err_acc + err);
    ctrl     = gain_p_q * err + gain_i_q * err_acc + gain_d_q * (err - err_last);
    ctrl     = clamp24(ctrl);
    err_last = err;
    // The left clamp takes the ceiling first and only otherwise the floor;
    // the right clamp applies the floor after the ceiling in any case.
    left = base_left_q + ctrl;
    if (left > max_left_q) begin
      left = max_left_q;
    end else if (left < MIN_SPEED) begin
      left = MIN_SPEED;
    end
    right = base_right_q - ctrl;
    if (right > max_right_q) begin
      right = max_right_q;
    end
    if (right < MIN_SPEED) begin
      right = MIN_SPEED;
    end
    if (left > ceiling) begin
      left = ceiling;
    end
    if (left < 0) begin
      left = 0;
    end
    if (right > ceiling) begin
      right = ceiling;
    end
    if (right < 0) begin
      right = 0;
    end
    res.left_drive    = left[DRIVE_W-1:0];
    res.right_drive   = right[DRIVE_W-1:0];
    res.control_value = ctrl[CTRL_W-1:0];
    res.line_position = pos_held[POS_W-1:0];
    return res;
  endfunction

  function automatic void report_mismatch(input string what, input drive_result_t exp_r,
                                          input drive_result_t got_r);
    drive_mismatches++;
    if (drive_mismatches <= REPORT_MAX) begin
      $display("%0t: %s: expected L=%0d R=%0d C=%0d P=%0d, got L=%0d R=%0d C=%0d P=%0d",
               $time, what, exp_r.left_drive, exp_r.right_drive,
               $signed(exp_r.control_value), $signed(exp_r.line_position),
               got_r.left_drive, got_r.right_drive,
               $signed(got_r.control_value), $signed(got_r.line_position));
    end
  endfunction

  // Compares one accepted result with the oldest prediction.
  function automatic void check_drive();
    drive_result_t got_r;
    drive_result_t exp_r;
    got_r.left_drive    = result_if.left_drive;
    got_r.right_drive   = result_if.right_drive;
    got_r.control_value = result_if.control_value;
    got_r.line_position = result_if.line_position;
    if (expected_drive_q.size() == 0) begin
      report_mismatch("result without request", '0, got_r);
    end else begin
      exp_r = expected_drive_q.pop_front();
      if (got_r.left_drive !== exp_r.left_drive ||
          got_r.right_drive !== exp_r.right_drive ||
          got_r.control_value !== exp_r.control_value ||
          got_r.line_position !== exp_r.line_position) begin
        report_mismatch("drive mismatch", exp_r, got_r);
      end
    end
  endfunction

  // Result side: checks on each accepted result, and holds off ready in
  // random bursts while idling is enabled.
  always @(posedge clk_i) begin
    if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      check_drive();
    end
    if (stall_left > 0) begin
      stall_left--;
      result_if.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  // Sends one sensor request and records its prediction once it is taken.
  // Valid stays high afterwards so back-to-back requests need no gap.
  task automatic send_sample(input logic [SENSOR_W-1:0] bits);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      sensor_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sensor_if.valid       <= 1'b1;
    sensor_if.sensor_bits <= bits;
    @(posedge clk_i);
    while (sensor_if.ready !== 1'b1) begin
      @(posedge clk_i);
    end
    expected_drive_q.push_back(predict_drive(bits));
  endtask

  // Drops valid and waits until every predicted result has come back, then
  // lets the pipeline settle for the given number of cycles.
  task automatic wait_drained(input int settle);
    sensor_if.valid <= 1'b0;
    while (expected_drive_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (settle) @(posedge clk_i);
  endtask

  // Writes all eight registers, one per cycle. The spare top bit of the
  // setpoint byte is driven too, since the block has to drop it.
  task automatic load_config(input cfg_t c, input logic spare_bit);
    logic [CFG_DATA_W-1:0] d;
    cfg_reg_e r;
    for (int i = 0; i < 8; i++) begin
      r = cfg_reg_e'(i);
      case (r)
        REG_GAIN_P:     d = c.gain_p;
        REG_GAIN_I:     d = c.gain_i;
        REG_GAIN_D:     d = c.gain_d;
        REG_TARGET:     d = {spare_bit, c.target};
        REG_BASE_LEFT:  d = c.base_left;
        REG_BASE_RIGHT: d = c.base_right;
        REG_MAX_LEFT:   d = c.max_left;
        default:        d = c.max_right;
      endcase
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= r;
      cfg_data_i <= d;
      @(posedge clk_i);
      apply_reg(r, d);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic cfg_t pick_config(input cfg_pick_e pick);
    cfg_t c;
    int   t;
    case (pick)
      CFG_ALL_HIGH: begin
        c = '{gain_p: 8'hFF, gain_i: 8'hFF, gain_d: 8'hFF, target: 7'h3F,
              base_left: 8'hFF, base_right: 8'hFF, max_left: 8'hFF, max_right: 8'hFF};
      end
      CFG_ALL_LOW: begin
        c = '{gain_p: 8'h00, gain_i: 8'h00, gain_d: 8'h00, target: 7'h40,
              base_left: 8'h00, base_right: 8'h00, max_left: 8'h00, max_right: 8'h00};
      end
      default: begin
        // Small gains most of the time so the drives land between the clamps.
        c.gain_p = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
        c.gain_i = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
        c.gain_d = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
        t = $urandom_range(0, 64) - 32;
        c.target     = ($urandom_range(0, 3) == 0) ? 7'($urandom) : t[POS_W-1:0];
        c.base_left  = 8'($urandom);
        c.base_right = 8'($urandom);
        c.max_left   = 8'($urandom);
        c.max_right  = 8'($urandom);
      end
    endcase
    return c;
  endfunction

  // Mostly valid line patterns, with some arbitrary sensor noise.
  function automatic logic [SENSOR_W-1:0] pick_sensor();
    if ($urandom_range(0, 3) == 0) begin
      return SENSOR_W'($urandom_range(0, 31));
    end
    return LINE_PATTERNS[$urandom_range(0, 11)];
  endfunction

  // With the reset gains, every known pattern decodes to its position, and
  // unknown patterns hold the last one.
  task automatic test_pattern_decode();
    for (int i = 0; i < 12; i++) begin
      send_sample(LINE_PATTERNS[i]);
    end
    send_sample(5'b00000);
    send_sample(5'b10101);
    send_sample(5'b01010);
  endtask

  // Setpoints beyond the decoded range, saturated control, and both clamps
  // on each wheel.
  task automatic test_setpoint_clamps();
    cfg_t c;
    wait_drained(3);
    load_config(pick_config(CFG_ALL_HIGH), 1'b0);
    send_sample(5'b00011);
    send_sample(5'b11000);
    send_sample(5'b01010);
    wait_drained(3);
    c = pick_config(CFG_ALL_LOW);
    c.gain_p = 8'd1;
    load_config(c, 1'b1);
    send_sample(5'b11000);
    send_sample(5'b00011);
    wait_drained(3);
    c = '{gain_p: 8'd1, gain_i: 8'd0, gain_d: 8'd0, target: 7'h00,
          base_left: 8'd100, base_right: 8'd100, max_left: 8'd120, max_right: 8'd90};
    load_config(c, 1'b1);
    send_sample(5'b11110);
    send_sample(5'b00111);
  endtask

  // Pushes the control value into its negative limit through the integral
  // term alone, then lets the error sum climb back out of it. Only the
  // integral gain is set, at its largest value.
  task automatic test_sum_saturation();
    cfg_t c;
    wait_drained(3);
    c = '{gain_p: 8'd0, gain_i: 8'hFF, gain_d: 8'd0, target: 7'h40,
          base_left: 8'd128, base_right: 8'd128, max_left: 8'hFF, max_right: 8'hFF};
    load_config(c, 1'b1);
    repeat (400) send_sample(5'b11000);
    wait_drained(3);
    c.target = 7'h3F;
    load_config(c, 1'b0);
    repeat (100) send_sample(5'b00011);
  endtask

  // Random phases, each with its own register set. Idling is on for most of
  // them and off for the fourth and the last two; one phase pauses the sender
  // mid-stream until the block has handed back everything it owes.
  task automatic test_random_traffic();
    cfg_pick_e pick;
    for (int phase = 0; phase < 10; phase++) begin
      wait_drained(3);
      idle_en = 1'b0;
      pick = (phase == 0) ? CFG_ALL_HIGH : (phase == 1) ? CFG_ALL_LOW : CFG_RANDOM;
      load_config(pick_config(pick), 1'($urandom));
      idle_en = (phase < 8) && (phase != 3);
      for (int n = 0; n < 60; n++) begin
        if (phase == 4 && n == 30) begin
          wait_drained(0);
        end
        send_sample(pick_sensor());
      end
    end
    idle_en = 1'b0;
  endtask

  initial begin
    drive_mismatches = 0;
    idle_en          = 1'b0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    sensor_if.valid       = 1'b0;
    sensor_if.sensor_bits = '0;
    // Prediction state matches what reset leaves in the block.
    gain_p_q     = int'(GAIN_P_RST);
    gain_i_q     = int'(GAIN_I_RST);
    gain_d_q     = int'(GAIN_D_RST);
    setpoint_q   = int'(TARGET_RST);
    base_left_q  = int'(BASE_RST);
    base_right_q = int'(BASE_RST);
    max_left_q   = int'(MAX_RST);
    max_right_q  = int'(MAX_RST);
    pos_held     = 0;
    err_acc      = 0;
    err_last     = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_pattern_decode();
    test_setpoint_clamps();
    test_sum_saturation();
    test_random_traffic();

    wait_drained(5);
    if (drive_mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
